// ----- rtl/fir_row_filter_abs_argmax_top_defines.svh -----
// Assertion macros used by the filter top module.
`ifndef FIR_ROW_FILTER_ABS_ARGMAX_TOP_DEFINES_SVH
`define FIR_ROW_FILTER_ABS_ARGMAX_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FRFA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FRFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/frfa_pkg.sv -----
// Types, sizes and codes shared by the row filter and argmax blocks.
package frfa_pkg;

    localparam int MAX_TAPS    = 31;
    localparam int MAX_COLUMNS = 65536;
    localparam int MAX_ROWS    = 256;
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 18;
    localparam int DEFAULT_TAPS = 23;

    localparam int TAPS_BITS   = 5;
    localparam int TAP_IDX_BITS = $clog2(MAX_TAPS);
    localparam int COL_BITS    = $clog2(MAX_COLUMNS);
    localparam int CNT_BITS    = $clog2(MAX_COLUMNS + 1);
    localparam int ROW_BITS    = $clog2(MAX_ROWS);
    localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS;
    localparam int SUM_BITS    = PROD_BITS + $clog2(MAX_TAPS);
    localparam int MAG_BITS    = 39;
    localparam int GROUP_SIZE  = 4;
    localparam int GROUPS      = (MAX_TAPS + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int GROUP_BITS  = PROD_BITS + $clog2(GROUP_SIZE);

    localparam int PADDR_BITS  = 3;
    localparam int PDATA_BITS  = 32;

    // Input item modes.
    localparam logic MODE_COEF   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    // Register select: address bit 2 picks the register word.
    localparam logic REG_TAPS = 1'b0;

    // Error codes.
    localparam logic ERR_NONE      = 1'b0;
    localparam logic ERR_SHORT_ROW = 1'b1;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_BITS-1:0]   coef_t;
    typedef logic signed [PROD_BITS-1:0]   prod_t;
    typedef logic signed [GROUP_BITS-1:0]  group_t;
    typedef logic signed [SUM_BITS-1:0]    sum_t;
    typedef logic [MAG_BITS-1:0]           mag_t;

    // Side information that travels down the pipeline with each sample.
    typedef struct packed {
        logic                has_out;
        logic                is_end;
        logic                err;
        logic [COL_BITS-1:0] col;
        logic [ROW_BITS-1:0] row;
    } tag_t;

endpackage

// ----- rtl/frfa_in_if.sv -----
// Input item channel: coefficient writes and matrix samples.
interface frfa_in_if;
    import frfa_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 mode;
    logic [4:0]           coef_index;
    coef_t                coef_value;
    sample_t              sample_value;
    logic                 row_last;
    logic                 matrix_last;

    modport source (output valid, mode, coef_index, coef_value, sample_value, row_last,
                    matrix_last, input ready);
    modport sink (input valid, mode, coef_index, coef_value, sample_value, row_last,
                  matrix_last, output ready);
endinterface

// ----- rtl/frfa_out_if.sv -----
// Result channel: position and magnitude of the largest filter output.
interface frfa_out_if;
    import frfa_pkg::*;

    logic                valid;
    logic                ready;
    logic [COL_BITS-1:0] best_sample;
    logic [ROW_BITS-1:0] best_key;
    mag_t                best_magnitude;
    logic                error;

    modport source (output valid, best_sample, best_key, best_magnitude, error,
                    input ready);
    modport sink (input valid, best_sample, best_key, best_magnitude, error,
                  output ready);
endinterface

// ----- rtl/fir_row_filter_abs_argmax_top.sv -----
// Row FIR filter with absolute argmax: stream control, cell row and register port.
// A matrix_last beat passes the window taps, products, group sums, total and magnitude, then loads the result.
// Throughput: one beat per cycle; the cell row, adder tree and argmax are fully pipelined.
// Input stalls only while a finished result waits and another matrix end is next in line.
// Reset clears all counters, the argmax state and taps_in_use (back to 23) at once.
// The coefficient table holds no reset value and must be written before use.
module fir_row_filter_abs_argmax_top (
    input  logic                                clk,
    input  logic                                rst_n,
    frfa_in_if.sink                             items,
    frfa_out_if.source                          results,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [frfa_pkg::PADDR_BITS-1:0]     paddr,
    input  logic [frfa_pkg::PDATA_BITS-1:0]     pwdata,
    output logic [frfa_pkg::PDATA_BITS-1:0]     prdata,
    output logic                                pready
);
    import frfa_pkg::*;

    logic [TAPS_BITS-1:0] taps_reg;
    logic [TAPS_BITS-1:0] t_eff;
    logic [CNT_BITS-1:0]  cc_reg;
    logic [CNT_BITS-1:0]  cc_inc;
    logic [CNT_BITS-1:0]  cc_next;
    logic [ROW_BITS-1:0]  row_reg;
    logic [ROW_BITS-1:0]  row_next;
    logic                 short_reg;
    logic                 short_next;
    logic                 short_now;
    logic                 take;
    logic                 is_sample;
    logic                 shift;
    logic                 row_end;
    logic                 mat_end;
    logic                 advance;
    logic                 hold;
    tag_t                 tag0;
    tag_t                 tag1_reg;
    tag_t                 tag2_reg;
    tag_t                 tag_sum;
    sum_t                 total;
    sample_t              taps_win [MAX_TAPS];
    sample_t              mult_sel [MAX_TAPS];
    logic                 active   [MAX_TAPS];
    prod_t                products [MAX_TAPS];

    // Register port.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TAPS) ? PDATA_BITS'(taps_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taps_reg <= TAPS_BITS'(DEFAULT_TAPS);
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_TAPS))
        begin
            taps_reg <= pwdata[TAPS_BITS-1:0];
        end
    end

    // Stream control for the accepted beat.
    assign advance     = !hold;
    assign items.ready = advance;

    always_comb
    begin
        t_eff = taps_reg;
        if (t_eff == '0)
        begin
            t_eff = TAPS_BITS'(1);
        end
        if (t_eff > TAPS_BITS'(MAX_TAPS))
        begin
            t_eff = TAPS_BITS'(MAX_TAPS);
        end

        take      = items.valid && items.ready;
        is_sample = take && (items.mode == MODE_SAMPLE);
        shift     = is_sample && (cc_reg < CNT_BITS'(MAX_COLUMNS));
        cc_inc    = shift ? cc_reg + CNT_BITS'(1) : cc_reg;
        row_end   = is_sample && (items.row_last || items.matrix_last);
        mat_end   = is_sample && items.matrix_last;
        short_now = row_end && (cc_inc < CNT_BITS'(t_eff));
        cc_next   = row_end ? '0 : cc_inc;

        row_next = row_reg;
        if (mat_end)
        begin
            row_next = '0;
        end
        else if (row_end && (row_reg < ROW_BITS'(MAX_ROWS - 1)))
        begin
            row_next = row_reg + ROW_BITS'(1);
        end

        short_next = mat_end ? 1'b0 : (short_reg || short_now);

        tag0.has_out = shift && (cc_inc >= CNT_BITS'(t_eff));
        tag0.is_end  = mat_end;
        tag0.err     = (short_reg || short_now) ? ERR_SHORT_ROW : ERR_NONE;
        tag0.col     = COL_BITS'(cc_inc - CNT_BITS'(t_eff));
        tag0.row     = row_reg;
    end

    // The tag waits one stage beside the window taps and one beside the products.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_reg    <= '0;
            row_reg   <= '0;
            short_reg <= 1'b0;
            tag1_reg  <= '0;
            tag2_reg  <= '0;
        end
        else
        begin
            cc_reg    <= cc_next;
            row_reg   <= row_next;
            short_reg <= short_next;
            if (advance)
            begin
                tag1_reg <= tag0;
                tag2_reg <= tag1_reg;
            end
        end
    end

    // Cell k multiplies coefficient k by the sample taps_in_use - 1 - k places back.
    always_comb
    begin
        for (int k = 0; k < MAX_TAPS; k++)
        begin
            active[k]   = k < int'(t_eff);
            mult_sel[k] = taps_win[TAP_IDX_BITS'(int'(t_eff) - 1 - k)];
        end
    end

    for (genvar k = 0; k < MAX_TAPS; k++)
    begin : g_cell
        sample_t cell_in;
        if (k == 0)
        begin : g_head
            assign cell_in = items.sample_value;
        end
        else
        begin : g_link
            assign cell_in = taps_win[k-1];
        end

        frfa_cell u_cell (
            .clk         (clk),
            .shift       (shift),
            .sample_in   (cell_in),
            .tap         (taps_win[k]),
            .coef_we     (take && (items.mode == MODE_COEF) &&
                          (items.coef_index == TAPS_BITS'(k))),
            .coef_in     (items.coef_value),
            .mult_sample (mult_sel[k]),
            .active      (active[k]),
            .advance     (advance),
            .product     (products[k])
        );
    end

    frfa_sum u_sum (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .products (products),
        .tag_in   (tag2_reg),
        .total    (total),
        .tag_out  (tag_sum)
    );

    frfa_track u_track (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .total   (total),
        .tag_in  (tag_sum),
        .hold    (hold),
        .results (results)
    );

`include "fir_row_filter_abs_argmax_top_defines.svh"

    `FRFA_ASSERT_NEXT(a_matrix_end_clears, clk, rst_n, mat_end, (row_reg == '0) && !short_reg && (cc_reg == '0), "matrix end did not clear the row state")
    `FRFA_ASSERT_IMPLY(a_column_bound, clk, rst_n, 1'b1, cc_reg <= CNT_BITS'(MAX_COLUMNS), "column counter passed its limit")
    `FRFA_ASSERT_IMPLY(a_no_beat_on_hold, clk, rst_n, hold, !take && !shift, "beat taken while a result was blocked")

endmodule

// ----- rtl/frfa_cell.sv -----
// One filter cell: a window tap, its coefficient and a registered product.
module frfa_cell (
    input  logic             clk,
    input  logic             shift,
    input  frfa_pkg::sample_t sample_in,
    output frfa_pkg::sample_t tap,
    input  logic             coef_we,
    input  frfa_pkg::coef_t  coef_in,
    input  frfa_pkg::sample_t mult_sample,
    input  logic             active,
    input  logic             advance,
    output frfa_pkg::prod_t  product
);
    import frfa_pkg::*;

    sample_t tap_reg;
    coef_t   coef_reg;
    prod_t   prod_reg;
    prod_t   prod_next;

    always_comb
    begin
        if (active)
        begin
            prod_next = mult_sample * coef_reg;
        end
        else
        begin
            prod_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            tap_reg <= sample_in;
        end
        if (coef_we)
        begin
            coef_reg <= coef_in;
        end
        if (advance)
        begin
            prod_reg <= prod_next;
        end
    end

    assign tap     = tap_reg;
    assign product = prod_reg;

endmodule

// ----- rtl/frfa_sum.sv -----
// Two-stage registered adder tree over the cell products.
module frfa_sum (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  frfa_pkg::prod_t products [frfa_pkg::MAX_TAPS],
    input  frfa_pkg::tag_t  tag_in,
    output frfa_pkg::sum_t  total,
    output frfa_pkg::tag_t  tag_out
);
    import frfa_pkg::*;

    group_t grp_reg  [GROUPS];
    group_t grp_next [GROUPS];
    tag_t   tag_a_reg;
    sum_t   total_reg;
    sum_t   total_next;
    tag_t   tag_b_reg;

    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            grp_next[g] = '0;
            for (int j = 0; j < GROUP_SIZE; j++)
            begin
                if (g * GROUP_SIZE + j < MAX_TAPS)
                begin
                    grp_next[g] = grp_next[g] + GROUP_BITS'(products[g * GROUP_SIZE + j]);
                end
            end
        end
    end

    always_comb
    begin
        total_next = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            total_next = total_next + SUM_BITS'(grp_reg[g]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            grp_reg   <= grp_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
        end
        else if (advance)
        begin
            tag_a_reg <= tag_in;
            tag_b_reg <= tag_a_reg;
        end
    end

    assign total   = total_reg;
    assign tag_out = tag_b_reg;

endmodule

// ----- rtl/frfa_track.sv -----
// Magnitude stage, running argmax and the result register.
module frfa_track (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  frfa_pkg::sum_t total,
    input  frfa_pkg::tag_t tag_in,
    output logic           hold,
    frfa_out_if.source     results
);
    import frfa_pkg::*;

    mag_t                mag_reg;
    tag_t                tag_reg;
    logic                none_seen_reg;
    mag_t                best_val_reg;
    logic [COL_BITS-1:0] best_col_reg;
    logic [ROW_BITS-1:0] best_row_reg;
    logic                wins;
    mag_t                upd_val;
    logic [COL_BITS-1:0] upd_col;
    logic [ROW_BITS-1:0] upd_row;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [COL_BITS-1:0] out_col_reg;
    logic [ROW_BITS-1:0] out_row_reg;
    mag_t                out_mag_reg;
    logic                out_err_reg;
    logic                load;

    // Ties go to the smaller column, then to the smaller row.
    always_comb
    begin
        wins = tag_reg.has_out &&
               (none_seen_reg || (mag_reg > best_val_reg) ||
                ((mag_reg == best_val_reg) &&
                 ((tag_reg.col < best_col_reg) ||
                  ((tag_reg.col == best_col_reg) && (tag_reg.row < best_row_reg)))));
        upd_val = wins ? mag_reg     : best_val_reg;
        upd_col = wins ? tag_reg.col : best_col_reg;
        upd_row = wins ? tag_reg.row : best_row_reg;
    end

    assign hold = tag_reg.is_end && out_valid_reg && !results.ready;
    assign load = advance && tag_reg.is_end;
    assign out_valid_next = (out_valid_reg && !results.ready) || load;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mag_reg <= (total < 0) ? MAG_BITS'(-total) : MAG_BITS'(total);
        end
        if (load)
        begin
            out_col_reg <= upd_col;
            out_row_reg <= upd_row;
            out_mag_reg <= upd_val;
            out_err_reg <= tag_reg.err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg       <= '0;
            none_seen_reg <= 1'b1;
            best_val_reg  <= '0;
            best_col_reg  <= '0;
            best_row_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                tag_reg <= tag_in;
                if (tag_reg.is_end)
                begin
                    none_seen_reg <= 1'b1;
                    best_val_reg  <= '0;
                    best_col_reg  <= '0;
                    best_row_reg  <= '0;
                end
                else if (wins)
                begin
                    none_seen_reg <= 1'b0;
                    best_val_reg  <= upd_val;
                    best_col_reg  <= upd_col;
                    best_row_reg  <= upd_row;
                end
            end
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.best_sample    = out_col_reg;
    assign results.best_key       = out_row_reg;
    assign results.best_magnitude = out_mag_reg;
    assign results.error          = out_err_reg;

endmodule
